// ===== hdl/two_list_sorted_merge_top_defines.svh =====
// Assertion macros shared by the two-list sorted merge block.
`ifndef TWO_LIST_SORTED_MERGE_TOP_DEFINES_SVH
`define TWO_LIST_SORTED_MERGE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define TLSM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define TLSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tlsm_pkg.sv =====
// Types and constants shared by the two-list sorted merge modules.
package tlsm_pkg;

  localparam logic [1:0] OP_PUSH_A = 2'd0;
  localparam logic [1:0] OP_PUSH_B = 2'd1;
  localparam logic [1:0] OP_MERGE  = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
  } tlsm_in_t;

  typedef struct packed {
    logic signed [31:0] merged_value;
    logic               last;
    logic               dropped;
  } tlsm_out_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_MERGE = 2'b10
  } tlsm_state_e;

  typedef struct packed {
    logic push_a;
    logic push_b;
    logic emit;
    logic take_a;
    logic last;
  } tlsm_cmd_t;

  typedef struct packed {
    logic a_left;
    logic b_left;
    logic a_one;
    logic b_one;
    logic a_lt_b;
    logic empty;
    logic out_free;
  } tlsm_status_t;

endpackage

// ===== hdl/two_list_sorted_merge_top.sv =====
// Top level of the two-list sorted merge block: controller, datapath and assertions.
//
// Push items (op 0 to list A, op 1 to list B) are taken one per cycle while idle; a push to a
// full list is discarded and flags dropped on the next merge's results. A merge
// item (op 2) with stored elements holds off the input until its final result,
// while the merge sequencer emits one result per cycle into the output register
// whenever the output is not stalled; the rate is set by the one read port of each
// list memory, whose registered head is fetched at the next index. A merge with
// both lists empty gives no result. Ties go to list B, the final result carries
// last, and both lists are empty afterwards.
module two_list_sorted_merge_top
  import tlsm_pkg::*;
#(
  parameter int LIST_DEPTH = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  tlsm_in_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output tlsm_out_t out_item_o
);

`include "two_list_sorted_merge_top_defines.svh"

  tlsm_cmd_t    cmd;
  tlsm_status_t status;

  tlsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_item_i.op),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  tlsm_datapath #(
    .LIST_DEPTH (LIST_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_value_i  (in_item_i.value),
    .out_stall_i (out_stall_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

  // A result is only taken while an element is still left in one of the lists.
  `TLSM_ASSERT_SAME(a_emit_nonempty, cmd.emit, status.a_left || status.b_left, "emit from empty lists")
  // No input item is accepted while the merge is emitting.
  `TLSM_ASSERT_SAME(a_emit_blocks_in, cmd.emit, in_stall_o, "input accepted during merge")
  // After the final result the lists are empty and input is taken again.
  `TLSM_ASSERT_NEXT(a_last_releases, cmd.emit && cmd.last, !in_stall_o && status.empty, "merge did not finish cleanly")

endmodule

// ===== hdl/tlsm_ctrl.sv =====
// Controller state machine: accepts items and sequences the merge one result at a time.
module tlsm_ctrl
  import tlsm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic [1:0]   in_op_i,
  input  tlsm_status_t status_i,
  output tlsm_cmd_t    cmd_o,
  output logic         in_stall_o
);

  tlsm_state_e state_q, state_d;
  logic        accept;
  logic        take_a;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  // On a tie the head of B goes first.
  assign take_a = status_i.a_left && (!status_i.b_left || status_i.a_lt_b);

  always_comb begin
    cmd_o        = '0;
    cmd_o.push_a = accept && (in_op_i == OP_PUSH_A);
    cmd_o.push_b = accept && (in_op_i == OP_PUSH_B);
    cmd_o.emit   = (state_q == ST_MERGE) && status_i.out_free;
    cmd_o.take_a = take_a;
    cmd_o.last   = take_a ? (status_i.a_one && !status_i.b_left)
                          : (status_i.b_one && !status_i.a_left);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_op_i == OP_MERGE) && !status_i.empty) begin
          state_d = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (cmd_o.emit && cmd_o.last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/tlsm_datapath.sv =====
// Datapath: the two list memories, counts, read heads, compare and the output register.
module tlsm_datapath
  import tlsm_pkg::*;
#(
  parameter int LIST_DEPTH = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  tlsm_cmd_t    cmd_i,
  input  logic [31:0]  in_value_i,
  input  logic         out_stall_i,
  output tlsm_status_t status_o,
  output logic         out_valid_o,
  output tlsm_out_t    out_item_o
);

  localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);

  logic [DATA_WIDTH-1:0] mem_a [LIST_DEPTH];
  logic [DATA_WIDTH-1:0] mem_b [LIST_DEPTH];

  logic [CW-1:0]         cnt_a_q, cnt_b_q;
  logic [CW-1:0]         ia_q, ib_q, ia_d, ib_d;
  logic                  ovf_q;
  logic [DATA_WIDTH-1:0] head_a_q, head_b_q;
  logic                  out_valid_q;
  tlsm_out_t             out_q;

  logic [63:0]              value_ext;
  logic [DATA_WIDTH-1:0]    wdata;
  logic                     full_a, full_b, clear;
  logic signed [DATA_WIDTH-1:0] sel;
  logic signed [63:0]       sel_ext;

  function automatic logic [IW-1:0] to_addr(input logic [CW-1:0] c);
    logic [IW-1:0] a;
    // A count equal to the depth has no entry behind it; read entry 0 instead.
    a = (c == FULL) ? '0 : c[IW-1:0];
    return a;
  endfunction

  // Pushed values keep the low bits of the zero-extended 32-bit field.
  assign value_ext = {32'b0, in_value_i};
  assign wdata     = value_ext[DATA_WIDTH-1:0];

  assign full_a = (cnt_a_q == FULL);
  assign full_b = (cnt_b_q == FULL);
  assign clear  = cmd_i.emit && cmd_i.last;

  always_comb begin
    ia_d = ia_q;
    ib_d = ib_q;
    if (cmd_i.emit) begin
      if (cmd_i.take_a) begin
        ia_d = ia_q + CW'(1);
      end else begin
        ib_d = ib_q + CW'(1);
      end
    end
  end

  // Heads are read at the next index so they are valid on the following cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_a && !full_a) begin
      mem_a[to_addr(cnt_a_q)] <= wdata;
    end
    if (cmd_i.push_b && !full_b) begin
      mem_b[to_addr(cnt_b_q)] <= wdata;
    end
    head_a_q <= mem_a[to_addr(clear ? '0 : ia_d)];
    head_b_q <= mem_b[to_addr(clear ? '0 : ib_d)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      ia_q    <= '0;
      ib_q    <= '0;
      ovf_q   <= 1'b0;
    end else if (clear) begin
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      ia_q    <= '0;
      ib_q    <= '0;
      ovf_q   <= 1'b0;
    end else begin
      ia_q <= ia_d;
      ib_q <= ib_d;
      if (cmd_i.push_a) begin
        if (full_a) begin
          ovf_q <= 1'b1;
        end else begin
          cnt_a_q <= cnt_a_q + CW'(1);
        end
      end
      if (cmd_i.push_b) begin
        if (full_b) begin
          ovf_q <= 1'b1;
        end else begin
          cnt_b_q <= cnt_b_q + CW'(1);
        end
      end
    end
  end

  assign sel     = cmd_i.take_a ? $signed(head_a_q) : $signed(head_b_q);
  assign sel_ext = 64'(sel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.merged_value <= sel_ext[31:0];
      out_q.last         <= cmd_i.last;
      out_q.dropped      <= ovf_q;
    end
  end

  assign status_o.a_left   = (ia_q != cnt_a_q);
  assign status_o.b_left   = (ib_q != cnt_b_q);
  assign status_o.a_one    = ((ia_q + CW'(1)) == cnt_a_q);
  assign status_o.b_one    = ((ib_q + CW'(1)) == cnt_b_q);
  assign status_o.a_lt_b   = ($signed(head_a_q) < $signed(head_b_q));
  assign status_o.empty    = (cnt_a_q == '0) && (cnt_b_q == '0);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
